// File: rtl/tslne_pkg.sv
// Shared types, character codes and a helper function for the text stream line number escape core.
package tslne_pkg;

    // Columns of the printed line number.
    localparam int NUMBER_DIGITS = 6;
    // Digits that may count up to nine; the counter never passes 999999.
    localparam int CAP_DIGITS    = (NUMBER_DIGITS < 6) ? NUMBER_DIGITS : 6;
    // Longest burst of output words one input word can cause.
    localparam int MAX_OUT       = NUMBER_DIGITS + 3;
    localparam int PTR_W         = $clog2(MAX_OUT);

    typedef logic [7:0]                      t_char;
    typedef logic [3:0]                      t_bcd;
    typedef t_bcd [NUMBER_DIGITS-1:0]        t_count;
    typedef logic [PTR_W-1:0]                t_ptr;

    // Character codes.
    localparam t_char CH_NL     = 8'h0A;
    localparam t_char CH_TAB    = 8'h09;
    localparam t_char CH_DEL    = 8'h7F;
    localparam t_char CH_CARET  = 8'h5E;
    localparam t_char CH_DOLLAR = 8'h24;
    localparam t_char CH_SPACE  = 8'h20;
    localparam t_char CH_ZERO   = 8'h30;
    localparam t_char CH_I      = 8'h49;
    localparam t_char CH_QMARK  = 8'h3F;
    localparam t_char CTRL_LAST = 8'd31;
    localparam t_char CTRL_BIAS = 8'd64;

    // Numbering modes; the unused code behaves as no numbering.
    localparam logic [1:0] NUM_ALL      = 2'd1;
    localparam logic [1:0] NUM_NONBLANK = 2'd2;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_NUMBER_MODE      = 3'd0,
        CFG_SQUEEZE_BLANK    = 3'd1,
        CFG_SHOW_ENDS        = 3'd2,
        CFG_SHOW_TABS        = 3'd3,
        CFG_SHOW_NONPRINTING = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0] number_mode;
        logic       squeeze_blank;
        logic       show_ends;
        logic       show_tabs;
        logic       show_nonprinting;
    } t_cfg;

    // One decoded input word: the output burst it causes, compacted from index 0.
    typedef struct packed {
        logic                 keep;
        t_char [MAX_OUT-1:0]  bytes;
        t_ptr                 last_idx;
    } t_job;

    // Saturation value of the line counter in BCD.
    function automatic t_count count_cap();
        t_count cap;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            cap[i] = (i < CAP_DIGITS) ? 4'd9 : 4'd0;
        end
        return cap;
    endfunction

endpackage

// File: rtl/tslne_line_state.sv
// Line state (counter, newline and blank-run tracking) and per-word decode into an output burst.
module tslne_line_state (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tslne_pkg::t_cfg   i_cfg,
    input  logic [7:0]        i_byte,
    input  logic              i_eof,
    input  logic              i_accept,
    output tslne_pkg::t_job   o_job
);
    import tslne_pkg::*;

    t_count     r_count, n_count, w_count_inc;
    logic       r_after_nl, n_after_nl;
    logic [1:0] r_blank, n_blank, w_blank_next;

    logic  w_nl, w_sq, w_skip, w_num_en, w_dollar, w_caret;
    t_char w_final;
    t_ptr  w_dpos, w_cpos, w_fpos;

    // BCD increment with ripple carry.
    always_comb begin
        logic carry;
        carry = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (carry && r_count[i] == 4'd9) begin
                w_count_inc[i] = 4'd0;
            end else if (carry) begin
                w_count_inc[i] = r_count[i] + 4'd1;
                carry = 1'b0;
            end else begin
                w_count_inc[i] = r_count[i];
            end
        end
    end

    always_comb begin
        w_nl   = (i_byte == CH_NL);
        w_sq   = i_cfg.squeeze_blank && w_nl && r_after_nl;
        if (!w_sq) begin
            w_blank_next = 2'd0;
        end else if (r_blank < 2'd2) begin
            w_blank_next = r_blank + 2'd1;
        end else begin
            w_blank_next = 2'd2;
        end
        w_skip   = w_sq && (w_blank_next > 2'd1);
        w_num_en = r_after_nl && ((i_cfg.number_mode == NUM_ALL) ||
                                  (i_cfg.number_mode == NUM_NONBLANK && !w_nl));
        w_dollar = i_cfg.show_ends && w_nl;

        w_caret = 1'b0;
        w_final = i_byte;
        if (i_cfg.show_tabs && i_byte == CH_TAB) begin
            w_caret = 1'b1;
            w_final = CH_I;
        end else if (i_cfg.show_nonprinting) begin
            if (i_byte inside {[8'd0:8'd8], [8'd11:CTRL_LAST]}) begin
                w_caret = 1'b1;
                w_final = i_byte + CTRL_BIAS;
            end else if (i_byte == CH_DEL) begin
                w_caret = 1'b1;
                w_final = CH_QMARK;
            end
        end
    end

    // Build the compacted burst: number and tab, then '$', then '^', then the byte.
    always_comb begin
        logic nz;
        nz = 1'b0;
        o_job.bytes = '0;
        if (w_num_en) begin
            for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
                nz = nz || (r_count[i] != 4'd0);
                o_job.bytes[NUMBER_DIGITS-1-i] = (nz || i == 0) ?
                    (CH_ZERO + {4'd0, r_count[i]}) : CH_SPACE;
            end
            o_job.bytes[NUMBER_DIGITS] = CH_TAB;
        end
        w_dpos = w_num_en ? t_ptr'(NUMBER_DIGITS + 1) : '0;
        w_cpos = w_dpos + {{(PTR_W-1){1'b0}}, w_dollar};
        w_fpos = w_cpos + {{(PTR_W-1){1'b0}}, w_caret};
        if (w_dollar) begin
            o_job.bytes[w_dpos] = CH_DOLLAR;
        end
        if (w_caret) begin
            o_job.bytes[w_cpos] = CH_CARET;
        end
        o_job.bytes[w_fpos] = w_final;
        o_job.last_idx      = w_fpos;
        o_job.keep          = !w_skip;
    end

    always_comb begin
        n_count    = r_count;
        n_after_nl = r_after_nl;
        n_blank    = r_blank;
        if (i_accept) begin
            if (i_eof) begin
                n_count    = '0;
                n_count[0] = 4'd1;
                n_after_nl = 1'b1;
                n_blank    = 2'd0;
            end else begin
                n_blank = w_blank_next;
                if (!w_skip) begin
                    n_after_nl = w_nl;
                    if (w_num_en && r_count != count_cap()) begin
                        n_count = w_count_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_count[0] <= 4'd1;
            r_after_nl <= 1'b1;
            r_blank    <= 2'd0;
        end else begin
            r_count    <= n_count;
            r_after_nl <= n_after_nl;
            r_blank    <= n_blank;
        end
    end

endmodule

// File: rtl/tslne_emit.sv
// Burst register and output register: plays one decoded burst out a word per cycle while the sink is ready.
module tslne_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tslne_pkg::t_job   i_job,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_m_valid,
    input  logic              i_m_ready,
    output logic [7:0]        o_m_data,
    output logic              o_m_last
);
    import tslne_pkg::*;

    logic                r_job_valid;
    t_char [MAX_OUT-1:0] r_bytes;
    t_ptr                r_last_idx;
    t_ptr                r_ptr;
    logic                r_out_valid;
    t_char               r_out_byte;
    logic                r_out_last;

    logic w_move, w_at_last, w_done, w_load;

    assign w_move    = r_job_valid && (!r_out_valid || i_m_ready);
    assign w_at_last = (r_ptr == r_last_idx);
    assign w_done    = w_move && w_at_last;
    assign o_ready   = !r_job_valid || w_done;
    assign w_load    = i_valid && o_ready && i_job.keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
        end else if (w_load) begin
            r_job_valid <= 1'b1;
        end else if (w_done) begin
            r_job_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_bytes    <= i_job.bytes;
            r_last_idx <= i_job.last_idx;
            r_ptr      <= '0;
        end else if (w_move) begin
            r_ptr      <= r_ptr + t_ptr'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_byte <= r_bytes[r_ptr];
            r_out_last <= w_at_last;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out_byte;
    assign o_m_last  = r_out_last;

endmodule

// File: rtl/text_stream_line_number_escape_core.sv
// Top level of the text stream line number escape core: ports, configuration and checks.
// A kept input word passes the burst register and then the output register before its first output word shows.
// Throughput: one input word per cycle when each causes one output word and the sink is ready;
// a word that causes more output words holds the input until the single output register has
// drained the burst register, one word per cycle while the sink is ready (at most NUMBER_DIGITS + 3 words).
// Reset (synchronous, active low) clears all configuration to zero, the line counter to
// one, marks start of line, and empties the burst and output registers.
module text_stream_line_number_escape_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [1:0]  i_cfg_data,
    // Input stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,    // [7:0] in_byte
    input  logic        i_s_axis_tlast,    // end_of_file
    // Output stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,    // [7:0] out_byte
    output logic        o_m_axis_tlast     // last_of_run
);
    import tslne_pkg::*;

    // Configuration registers. The user must see that they are written only while the core
    // is idle (the core itself does not enforce it), so the decode logic can read them directly.
    t_cfg r_cfg;
    t_job w_job;
    logic w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_NUMBER_MODE:      r_cfg.number_mode      <= i_cfg_data;
                CFG_SQUEEZE_BLANK:    r_cfg.squeeze_blank    <= i_cfg_data[0];
                CFG_SHOW_ENDS:        r_cfg.show_ends        <= i_cfg_data[0];
                CFG_SHOW_TABS:        r_cfg.show_tabs        <= i_cfg_data[0];
                CFG_SHOW_NONPRINTING: r_cfg.show_nonprinting <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    // The line state decodes the incoming word into a compact burst of output
    // words and updates its counters on acceptance. A squeezed blank line yields
    // a burst marked as not kept; it updates state but emits nothing.
    tslne_line_state u_line_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_byte   (i_s_axis_tdata),
        .i_eof    (i_s_axis_tlast),
        .i_accept (w_accept),
        .o_job    (w_job)
    );

    // The emitter holds one burst and moves it into the output register one word per cycle
    // while the sink is ready. It takes the next burst in the same cycle its last word moves.
    tslne_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (w_job),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_m_data  (o_m_axis_tdata),
        .o_m_last  (o_m_axis_tlast)
    );

    // The burst always ends inside the burst register.
    a_last_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (w_job.last_idx <= t_ptr'(MAX_OUT - 1)))
        else $error("burst end index out of range");

    // Words of one burst follow each other without gaps while the sink takes them.
    a_burst_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tlast && i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("gap inside an output burst");

    // The output is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // A word offered on the output holds still until the sink takes it.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("output word changed while stalled");

endmodule
